// ===== hw/rtl/mvm_pkg.sv =====
// ----------------------------------------------------------------------------
// mvm_pkg
// Shared types and constants for the matrix-vector multiply block.
// ----------------------------------------------------------------------------
package mvm_pkg;

  localparam int unsigned MaxColumns = 64;
  localparam int unsigned MaxRows    = 64;
  localparam int unsigned ColIdxW    = $clog2(MaxColumns);
  localparam int unsigned RowIdxW    = $clog2(MaxRows);
  localparam int unsigned CountW     = 7;
  localparam int unsigned ElemW      = 16;
  localparam int unsigned ProdW      = 2 * ElemW;
  localparam int unsigned AccW       = 38;
  localparam int unsigned ResultW    = 32;
  localparam int unsigned OutRowW    = 6;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  typedef enum logic [0:0] {
    KindVector = 1'b0,
    KindMatrix = 1'b1
  } kind_e;

  typedef enum logic [0:0] {
    RegColumns = 1'b0,
    RegRows    = 1'b1
  } cfg_reg_e;

  // one matrix element on its way from front to back
  typedef struct packed {
    logic signed [ElemW-1:0] element;
    logic signed [ElemW-1:0] stored;
    logic                    row_end;
    logic [OutRowW-1:0]      row_idx;
    logic                    last;
  } work_t;

endpackage

// ===== hw/rtl/mvm_front.sv =====
// ----------------------------------------------------------------------------
// mvm_front
// Accepts items, keeps the vector store and the load, column and row
// positions, and hands matrix elements with their vector operand onward.
// ----------------------------------------------------------------------------
module mvm_front import mvm_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [0:0]               cfg_index_i,
  input  logic [CountW-1:0]        cfg_data_i,
  input  logic                     push_i,
  output logic                     full_o,
  input  logic [0:0]               kind_i,
  input  logic signed [ElemW-1:0]  element_value_i,
  output logic                     work_valid_o,
  input  logic                     work_full_i,
  output work_t                    work_o
);

  logic [CountW-1:0]        cols_cfg_q, rows_cfg_q;
  logic [CountW-1:0]        cols, rows;
  logic [ColIdxW-1:0]       load_q, load_d;
  logic [ColIdxW-1:0]       col_q, col_d;
  logic [RowIdxW-1:0]       row_q, row_d;
  logic [CountW-1:0]        load_nxt, col_nxt, row_nxt;
  logic                     accept, is_matrix, stage_ready;
  logic                     stage_valid_q, stage_valid_d;
  logic signed [ElemW-1:0]  elem_q;
  logic                     row_end_q, last_q;
  logic [OutRowW-1:0]       row_idx_q;
  logic [ElemW-1:0]         store_mem [MaxColumns];
  logic [ElemW-1:0]         rd_q;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cols = cols_cfg_q;
    if (cols_cfg_q == '0) cols = CountW'(1);
    else if (cols_cfg_q > CountW'(MaxColumns)) cols = CountW'(MaxColumns);
    rows = rows_cfg_q;
    if (rows_cfg_q == '0) rows = CountW'(1);
    else if (rows_cfg_q > CountW'(MaxRows)) rows = CountW'(MaxRows);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_cfg_q <= CountW'(MaxColumns);
      rows_cfg_q <= CountW'(MaxRows);
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegColumns: cols_cfg_q <= cfg_data_i;
        RegRows:    rows_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign stage_ready = !stage_valid_q || !work_full_i;
  assign full_o      = !stage_ready;
  assign accept      = push_i && stage_ready;
  assign is_matrix   = (kind_e'(kind_i) == KindMatrix);

  assign load_nxt = {1'b0, load_q} + CountW'(1);
  assign col_nxt  = {1'b0, col_q} + CountW'(1);
  assign row_nxt  = {1'b0, row_q} + CountW'(1);

  always_comb begin
    load_d = load_q;
    col_d  = col_q;
    row_d  = row_q;
    if (accept && !is_matrix) begin
      load_d = (load_nxt >= cols) ? '0 : load_nxt[ColIdxW-1:0];
    end
    if (accept && is_matrix) begin
      if (col_nxt >= cols) begin
        col_d = '0;
        row_d = (row_nxt >= rows) ? '0 : row_nxt[RowIdxW-1:0];
      end else begin
        col_d = col_nxt[ColIdxW-1:0];
      end
    end
  end

  always_comb begin
    stage_valid_d = stage_valid_q;
    if (stage_valid_q && !work_full_i) stage_valid_d = 1'b0;
    if (accept && is_matrix) stage_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q        <= '0;
      col_q         <= '0;
      row_q         <= '0;
      stage_valid_q <= 1'b0;
    end else begin
      load_q        <= load_d;
      col_q         <= col_d;
      row_q         <= row_d;
      stage_valid_q <= stage_valid_d;
    end
  end

  // vector store: loads write, matrix elements read
  always_ff @(posedge clk_i) begin
    if (accept && !is_matrix) store_mem[load_q] <= element_value_i;
    if (accept && is_matrix) rd_q <= store_mem[col_q];
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_matrix) begin
      elem_q    <= element_value_i;
      row_end_q <= (col_nxt >= cols);
      row_idx_q <= OutRowW'(row_q);
      last_q    <= (row_nxt >= rows);
    end
  end

  assign work_valid_o   = stage_valid_q;
  assign work_o.element = elem_q;
  assign work_o.stored  = rd_q;
  assign work_o.row_end = row_end_q;
  assign work_o.row_idx = row_idx_q;
  assign work_o.last    = last_q;

endmodule

// ===== hw/rtl/mvm_queue.sv =====
// ----------------------------------------------------------------------------
// mvm_queue
// Short queue of matrix elements between the front and the back.
// ----------------------------------------------------------------------------
module mvm_queue import mvm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  work_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output work_t data_o
);

  work_t                entries_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, rd_q;
  logic [QueuePtrW:0]   cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == (QueuePtrW+1)'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = entries_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) entries_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + QueuePtrW'(1);
      if (do_pop) rd_q <= rd_q + QueuePtrW'(1);
      if (do_push && !do_pop) cnt_q <= cnt_q + (QueuePtrW+1)'(1);
      else if (!do_push && do_pop) cnt_q <= cnt_q - (QueuePtrW+1)'(1);
    end
  end

endmodule

// ===== hw/rtl/mvm_back.sv =====
// ----------------------------------------------------------------------------
// mvm_back
// Multiply-accumulate pipeline with saturation and a two-entry result queue.
// ----------------------------------------------------------------------------
module mvm_back import mvm_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      work_valid_i,
  input  work_t                     work_i,
  output logic                      work_pop_o,
  output logic                      empty_o,
  input  logic                      pop_i,
  output logic signed [ResultW-1:0] row_result_o,
  output logic [OutRowW-1:0]        row_index_o,
  output logic                      saturated_o,
  output logic                      last_row_o
);

  logic                      prod_valid_q;
  logic signed [ProdW-1:0]   prod_q;
  logic                      row_end_q, last_q;
  logic [OutRowW-1:0]        row_idx_q;
  logic                      prod_ready, acc_fire;
  logic signed [AccW-1:0]    acc_q, sum;
  logic                      pos_ovf, neg_ovf;
  logic [ResultW-1:0]        res_val;

  logic [ResultW-1:0]        oq_val_q [2];
  logic [OutRowW-1:0]        oq_idx_q [2];
  logic                      oq_sat_q [2];
  logic                      oq_last_q [2];
  logic                      oq_wr_q, oq_rd_q;
  logic [1:0]                oq_cnt_q;
  logic                      oq_full, oq_push, oq_pop;

  assign oq_full    = (oq_cnt_q == 2'd2);
  assign acc_fire   = prod_valid_q && (!row_end_q || !oq_full);
  assign prod_ready = !prod_valid_q || acc_fire;
  assign work_pop_o = work_valid_i && prod_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
    end else if (prod_ready) begin
      prod_valid_q <= work_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (work_pop_o) begin
      prod_q    <= ProdW'(work_i.element) * ProdW'(work_i.stored);
      row_end_q <= work_i.row_end;
      row_idx_q <= work_i.row_idx;
      last_q    <= work_i.last;
    end
  end

  assign sum     = acc_q + {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};
  assign pos_ovf = !sum[AccW-1] && (|sum[AccW-2:ResultW-1]);
  assign neg_ovf = sum[AccW-1] && !(&sum[AccW-2:ResultW-1]);

  always_comb begin
    res_val = sum[ResultW-1:0];
    if (pos_ovf) res_val = {1'b0, {(ResultW-1){1'b1}}};
    if (neg_ovf) res_val = {1'b1, {(ResultW-1){1'b0}}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (acc_fire) begin
      acc_q <= row_end_q ? '0 : sum;
    end
  end

  // result queue
  assign oq_push = acc_fire && row_end_q;
  assign oq_pop  = pop_i && !empty_o;
  assign empty_o = (oq_cnt_q == 2'd0);

  always_ff @(posedge clk_i) begin
    if (oq_push) begin
      oq_val_q[oq_wr_q]  <= res_val;
      oq_idx_q[oq_wr_q]  <= row_idx_q;
      oq_sat_q[oq_wr_q]  <= pos_ovf || neg_ovf;
      oq_last_q[oq_wr_q] <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= 1'b0;
      oq_rd_q  <= 1'b0;
      oq_cnt_q <= 2'd0;
    end else begin
      if (oq_push) oq_wr_q <= !oq_wr_q;
      if (oq_pop) oq_rd_q <= !oq_rd_q;
      if (oq_push && !oq_pop) oq_cnt_q <= oq_cnt_q + 2'd1;
      else if (!oq_push && oq_pop) oq_cnt_q <= oq_cnt_q - 2'd1;
    end
  end

  assign row_result_o = oq_val_q[oq_rd_q];
  assign row_index_o  = oq_idx_q[oq_rd_q];
  assign saturated_o  = oq_sat_q[oq_rd_q];
  assign last_row_o   = oq_last_q[oq_rd_q];

endmodule

// ===== hw/rtl/matrix_vector_multiply.sv =====
// Matrix-vector multiply in signed Q8.8 with Q16.16 saturated row results.
// Takes one item per cycle while full_o is low, vector loads and matrix
// elements alike, and produces one multiply-accumulate per cycle unless the
// result queue is full at a row's end; a row's last element passes through
// the front stage, the element queue and the product register, after which
// the 38-bit accumulate and saturation write the result queue.
// Configuration is written through the cfg channel, which is always
// ready: index 0 sets the column count, index 1 the row count.
// ----------------------------------------------------------------------------
// matrix_vector_multiply
// Top level: front with vector store, element queue, and MAC back end.
// ----------------------------------------------------------------------------
module matrix_vector_multiply import mvm_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [0:0]                cfg_index_i,
  input  logic [CountW-1:0]         cfg_data_i,
  input  logic                      push_i,
  output logic                      full_o,
  input  logic [0:0]                kind_i,
  input  logic signed [ElemW-1:0]   element_value_i,
  output logic                      empty_o,
  input  logic                      pop_i,
  output logic signed [ResultW-1:0] row_result_o,
  output logic [OutRowW-1:0]        row_index_o,
  output logic                      saturated_o,
  output logic                      last_row_o
);

  logic  fw_valid, q_full, q_valid, q_pop;
  work_t fw_data, q_data;

  mvm_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .push_i          (push_i),
    .full_o          (full_o),
    .kind_i          (kind_i),
    .element_value_i (element_value_i),
    .work_valid_o    (fw_valid),
    .work_full_i     (q_full),
    .work_o          (fw_data)
  );

  mvm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fw_valid),
    .data_i  (fw_data),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  mvm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .work_valid_i (q_valid),
    .work_i       (q_data),
    .work_pop_o   (q_pop),
    .empty_o      (empty_o),
    .pop_i        (pop_i),
    .row_result_o (row_result_o),
    .row_index_o  (row_index_o),
    .saturated_o  (saturated_o),
    .last_row_o   (last_row_o)
  );

endmodule
